/* hw/rtl/fdep_pkg.sv */
// Package for the FAT directory entry parser.
// Holds the action, status and state codes, the control word of the name store and the byte
// constants. No dependencies.
`default_nettype none

package fdep_pkg;

    // Input actions
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Result status codes
    typedef enum logic [2:0] {
        ST_END     = 3'd0,
        ST_DELETED = 3'd1,
        ST_LFN     = 3'd2,
        ST_SKIP    = 3'd3,
        ST_FILE    = 3'd4,
        ST_CHAR    = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CLASSIFY,
        S_LFN,
        S_FCHK,
        S_SHORT,
        S_DOT,
        S_TERM,
        S_EMIT
    } t_state;

    // Name store control word
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } t_store_ctl;

    // Widths and limits fixed by the entry format
    localparam int unsigned LFN_AW = 10;           // (63 - 1) * 13 + 12 fits in 10 bits
    localparam logic [4:0] ENTRY_LAST = 5'd31;
    localparam logic [3:0] LFN_LAST   = 4'd12;
    localparam logic [3:0] NAME_LAST  = 4'd7;
    localparam logic [3:0] EXT_LAST   = 4'd10;
    localparam logic [4:0] ATTR_BYTE  = 5'd11;

    // Byte values
    localparam logic [7:0] MARK_FREE    = 8'h00;
    localparam logic [7:0] MARK_DELETED = 8'hE5;
    localparam logic [7:0] ATTR_LFN     = 8'h0F;
    localparam logic [7:0] ATTR_SKIP    = 8'h0E;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [5:0] SEQ_MASK     = 6'h3F;

    // Entry byte offsets of the 13 long-name characters (low byte of each UTF-16 unit)
    localparam logic [4:0] LFN_OFFSETS [0:12] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
    };

endpackage

`default_nettype wire

/* hw/rtl/fdep_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fdep_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/fdep_name_store.sv */
// Long-name store: RAM plus one valid bit per cell; a cell never written since the last clear
// reads as zero. Depends on fdep_pkg and fdep_ram.
`default_nettype none

module fdep_name_store #(
    parameter int unsigned SIZE = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire fdep_pkg::t_store_ctl    i_ctl,
    input  wire logic [$clog2(SIZE)-1:0] i_wr_addr,
    input  wire logic [7:0]              i_wr_data,
    input  wire logic [$clog2(SIZE)-1:0] i_rd_addr,
    output logic      [7:0]              o_rd_data
);

    logic [SIZE-1:0] r_valid;
    logic            r_rd_valid;
    logic [7:0]      ram_q;

    // Valid bits: clear all at once, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Valid bit of the cell being read, aligned with the RAM output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_ctl.rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    fdep_ram #(
        .WIDTH (8),
        .DEPTH (SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    assign o_rd_data = r_rd_valid ? ram_q : 8'h00;

endmodule

`default_nettype wire

/* hw/rtl/fat_directory_entry_parser.sv */
// FAT directory entry parser: top level with the entry buffer, the sequencer and output word.
// An entry byte that does not complete an entry is taken in S_IDLE. A read goes through S_READ.
// Entry end: S_CLASSIFY, then S_EMIT for end, deleted, skipped, long-name part with sequence 0;
// S_LFN first for a long-name part (up to 13 store writes), S_FCHK for a file, S_SHORT/S_DOT/S_TERM for NAME.EXT.
// Busy while the sequencer runs; the store write port is the shared resource.
// Synchronous reset clears control state; the store reads as zero through its valid bits.
// Depends on fdep_pkg and fdep_name_store.
`default_nettype none

module fat_directory_entry_parser #(
    parameter int unsigned LONG_NAME_SIZE = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_entry_byte,
    input  wire logic [5:0]  i_char_index,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_entry_index,
    output logic [63:0]      o_short_name,
    output logic [23:0]      o_short_ext,
    output logic [7:0]       o_attributes,
    output logic [31:0]      o_file_length,
    output logic [31:0]      o_first_cluster,
    output logic [7:0]       o_name_char
);

    localparam int unsigned AW = $clog2(LONG_NAME_SIZE);
    localparam logic [fdep_pkg::LFN_AW-1:0] WR_LIMIT = fdep_pkg::LFN_AW'(LONG_NAME_SIZE - 1);
    localparam logic [fdep_pkg::LFN_AW-1:0] RD_LIMIT = fdep_pkg::LFN_AW'(LONG_NAME_SIZE);

    // Control registers
    fdep_pkg::t_state  r_state, n_state;
    fdep_pkg::t_status r_status, n_status;
    logic [4:0]        r_byte_pos, n_byte_pos;
    logic [15:0]       r_entry_count, n_entry_count;
    logic [15:0]       r_res_index, n_res_index;
    logic              r_ended, n_ended;
    logic              r_clr_pend, n_clr_pend;
    logic              r_rd_ok, n_rd_ok;
    logic [3:0]        r_idx, n_idx;
    logic [3:0]        r_pos, n_pos;
    logic [7:0]        r_last, n_last;
    logic [fdep_pkg::LFN_AW-1:0] r_base, n_base;
    logic              r_out_valid, n_out_valid;

    // Output payload registers
    logic [2:0]  r_out_status, n_out_status;
    logic [15:0] r_out_index, n_out_index;
    logic [63:0] r_out_name, n_out_name;
    logic [23:0] r_out_ext, n_out_ext;
    logic [7:0]  r_out_attr, n_out_attr;
    logic [31:0] r_out_length, n_out_length;
    logic [31:0] r_out_cluster, n_out_cluster;
    logic [7:0]  r_out_char, n_out_char;

    // Entry buffer
    logic [7:0] r_entry_bytes [0:31];
    logic       byte_we;

    // Name store interface
    fdep_pkg::t_store_ctl store_ctl;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           store_q;

    logic in_acc;
    logic out_free;

    assign o_in_stall = (r_state != fdep_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    fdep_name_store #(
        .SIZE (LONG_NAME_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (store_q)
    );

    // Entry buffer write
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            r_entry_bytes[r_byte_pos] <= i_entry_byte;
        end
    end

    // Sequencer: next state, store control, result word
    always_comb begin
        logic [7:0]                  first;
        logic [7:0]                  attr;
        logic [7:0]                  sel_byte;
        logic [5:0]                  seq_m1;
        logic [fdep_pkg::LFN_AW-1:0] lfn_addr;
        logic [fdep_pkg::LFN_AW-1:0] idx_ext;
        logic                        is_file;

        first    = r_entry_bytes[0];
        attr     = r_entry_bytes[fdep_pkg::ATTR_BYTE];
        sel_byte = 8'h00;
        seq_m1   = (first[5:0] & fdep_pkg::SEQ_MASK) - 6'd1;
        lfn_addr = r_base + fdep_pkg::LFN_AW'(r_idx);
        idx_ext  = fdep_pkg::LFN_AW'(i_char_index);
        is_file  = (r_status == fdep_pkg::ST_FILE);

        n_state       = r_state;
        n_status      = r_status;
        n_byte_pos    = r_byte_pos;
        n_entry_count = r_entry_count;
        n_res_index   = r_res_index;
        n_ended       = r_ended;
        n_clr_pend    = r_clr_pend;
        n_rd_ok       = r_rd_ok;
        n_idx         = r_idx;
        n_pos         = r_pos;
        n_last        = r_last;
        n_base        = r_base;
        n_out_valid   = r_out_valid && i_out_stall;

        n_out_status  = r_out_status;
        n_out_index   = r_out_index;
        n_out_name    = r_out_name;
        n_out_ext     = r_out_ext;
        n_out_attr    = r_out_attr;
        n_out_length  = r_out_length;
        n_out_cluster = r_out_cluster;
        n_out_char    = r_out_char;

        byte_we   = 1'b0;
        store_ctl = '0;
        wr_addr   = '0;
        wr_data   = 8'h00;
        rd_addr   = '0;

        unique case (r_state)
            fdep_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (fdep_pkg::t_action'(i_action))
                        fdep_pkg::ACT_START: begin
                            store_ctl.clear = 1'b1;
                            n_byte_pos      = 5'd0;
                            n_entry_count   = 16'd0;
                            n_ended         = 1'b0;
                            n_clr_pend      = 1'b0;
                        end
                        fdep_pkg::ACT_BYTE: begin
                            if (!r_ended) begin
                                if (r_clr_pend) begin
                                    store_ctl.clear = 1'b1;
                                    n_clr_pend      = 1'b0;
                                end
                                byte_we = 1'b1;
                                if (r_byte_pos == fdep_pkg::ENTRY_LAST) begin
                                    n_byte_pos    = 5'd0;
                                    n_res_index   = r_entry_count;
                                    n_entry_count = r_entry_count + 16'd1;
                                    n_state       = fdep_pkg::S_CLASSIFY;
                                end else begin
                                    n_byte_pos = r_byte_pos + 5'd1;
                                end
                            end
                        end
                        fdep_pkg::ACT_READ: begin
                            store_ctl.rd_en = 1'b1;
                            rd_addr         = idx_ext[AW-1:0];
                            n_rd_ok         = (idx_ext < RD_LIMIT);
                            n_state         = fdep_pkg::S_READ;
                        end
                        default: ;
                    endcase
                end
            end

            fdep_pkg::S_READ: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = fdep_pkg::ST_CHAR;
                    n_out_index   = 16'd0;
                    n_out_name    = 64'd0;
                    n_out_ext     = 24'd0;
                    n_out_attr    = 8'h00;
                    n_out_length  = 32'd0;
                    n_out_cluster = 32'd0;
                    n_out_char    = r_rd_ok ? store_q : 8'h00;
                    n_state       = fdep_pkg::S_IDLE;
                end
            end

            // Classify the complete entry
            fdep_pkg::S_CLASSIFY: begin
                if (first == fdep_pkg::MARK_FREE) begin
                    n_ended  = 1'b1;
                    n_status = fdep_pkg::ST_END;
                    n_state  = fdep_pkg::S_EMIT;
                end else if (first == fdep_pkg::MARK_DELETED) begin
                    n_status = fdep_pkg::ST_DELETED;
                    n_state  = fdep_pkg::S_EMIT;
                end else if (attr == fdep_pkg::ATTR_LFN) begin
                    n_status = fdep_pkg::ST_LFN;
                    n_idx    = 4'd0;
                    // base = (seq - 1) * 13
                    n_base   = (fdep_pkg::LFN_AW'(seq_m1) << 3)
                             + (fdep_pkg::LFN_AW'(seq_m1) << 2)
                             + fdep_pkg::LFN_AW'(seq_m1);
                    if ((first[5:0] & fdep_pkg::SEQ_MASK) == 6'd0) begin
                        n_state = fdep_pkg::S_EMIT;
                    end else begin
                        n_state = fdep_pkg::S_LFN;
                    end
                end else if ((attr & fdep_pkg::ATTR_SKIP) != 8'h00) begin
                    store_ctl.clear = 1'b1;
                    n_status        = fdep_pkg::ST_SKIP;
                    n_state         = fdep_pkg::S_EMIT;
                end else begin
                    // file: look at store cell 0 to see if a long name is present
                    n_status        = fdep_pkg::ST_FILE;
                    n_clr_pend      = 1'b1;
                    store_ctl.rd_en = 1'b1;
                    rd_addr         = '0;
                    n_state         = fdep_pkg::S_FCHK;
                end
            end

            // One long-name character per cycle; cells at or past the last are dropped
            fdep_pkg::S_LFN: begin
                sel_byte = r_entry_bytes[fdep_pkg::LFN_OFFSETS[r_idx]];
                if (lfn_addr < WR_LIMIT) begin
                    store_ctl.wr_en = 1'b1;
                    wr_addr         = lfn_addr[AW-1:0];
                    wr_data         = sel_byte;
                end
                if (r_idx == fdep_pkg::LFN_LAST) begin
                    n_state = fdep_pkg::S_EMIT;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end

            fdep_pkg::S_FCHK: begin
                if (store_q == 8'h00 && first != fdep_pkg::CHAR_DOT) begin
                    n_idx   = 4'd0;
                    n_pos   = 4'd0;
                    n_state = fdep_pkg::S_SHORT;
                end else begin
                    n_state = fdep_pkg::S_EMIT;
                end
            end

            // Copy short-name bytes, skipping spaces
            fdep_pkg::S_SHORT: begin
                sel_byte = r_entry_bytes[5'(r_idx)];
                if (sel_byte != fdep_pkg::CHAR_SPACE) begin
                    store_ctl.wr_en = 1'b1;
                    wr_addr         = AW'(r_pos);
                    wr_data         = sel_byte;
                    n_pos           = r_pos + 4'd1;
                    n_last          = sel_byte;
                end
                if (r_idx == fdep_pkg::NAME_LAST) begin
                    n_state = fdep_pkg::S_DOT;
                end else if (r_idx == fdep_pkg::EXT_LAST) begin
                    n_state = fdep_pkg::S_TERM;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end

            fdep_pkg::S_DOT: begin
                store_ctl.wr_en = 1'b1;
                wr_addr         = AW'(r_pos);
                wr_data         = fdep_pkg::CHAR_DOT;
                n_pos           = r_pos + 4'd1;
                n_last          = fdep_pkg::CHAR_DOT;
                n_idx           = r_idx + 4'd1;
                n_state         = fdep_pkg::S_SHORT;
            end

            // Terminator; overwrites a trailing dot
            fdep_pkg::S_TERM: begin
                store_ctl.wr_en = 1'b1;
                wr_addr         = (r_last == fdep_pkg::CHAR_DOT) ? AW'(r_pos - 4'd1) : AW'(r_pos);
                wr_data         = 8'h00;
                n_state         = fdep_pkg::S_EMIT;
            end

            fdep_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_index   = r_res_index;
                    n_out_name    = is_file ? {r_entry_bytes[0], r_entry_bytes[1],
                                               r_entry_bytes[2], r_entry_bytes[3],
                                               r_entry_bytes[4], r_entry_bytes[5],
                                               r_entry_bytes[6], r_entry_bytes[7]} : 64'd0;
                    n_out_ext     = is_file ? {r_entry_bytes[8], r_entry_bytes[9],
                                               r_entry_bytes[10]} : 24'd0;
                    n_out_attr    = is_file ? attr : 8'h00;
                    n_out_length  = is_file ? {r_entry_bytes[31], r_entry_bytes[30],
                                               r_entry_bytes[29], r_entry_bytes[28]} : 32'd0;
                    n_out_cluster = is_file ? {r_entry_bytes[21], r_entry_bytes[20],
                                               r_entry_bytes[27], r_entry_bytes[26]} : 32'd0;
                    n_out_char    = 8'h00;
                    n_state       = fdep_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = fdep_pkg::S_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fdep_pkg::S_IDLE;
            r_status      <= fdep_pkg::ST_END;
            r_byte_pos    <= 5'd0;
            r_entry_count <= 16'd0;
            r_res_index   <= 16'd0;
            r_ended       <= 1'b0;
            r_clr_pend    <= 1'b0;
            r_rd_ok       <= 1'b0;
            r_idx         <= 4'd0;
            r_pos         <= 4'd0;
            r_last        <= 8'h00;
            r_base        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_status      <= n_status;
            r_byte_pos    <= n_byte_pos;
            r_entry_count <= n_entry_count;
            r_res_index   <= n_res_index;
            r_ended       <= n_ended;
            r_clr_pend    <= n_clr_pend;
            r_rd_ok       <= n_rd_ok;
            r_idx         <= n_idx;
            r_pos         <= n_pos;
            r_last        <= n_last;
            r_base        <= n_base;
            r_out_valid   <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_index   <= n_out_index;
        r_out_name    <= n_out_name;
        r_out_ext     <= n_out_ext;
        r_out_attr    <= n_out_attr;
        r_out_length  <= n_out_length;
        r_out_cluster <= n_out_cluster;
        r_out_char    <= n_out_char;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_index   = r_out_index;
    assign o_short_name    = r_out_name;
    assign o_short_ext     = r_out_ext;
    assign o_attributes    = r_out_attr;
    assign o_file_length   = r_out_length;
    assign o_first_cluster = r_out_cluster;
    assign o_name_char     = r_out_char;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Testbench for the FAT directory entry parser: directed and random directory listings,
// checked word by word against a parser model kept inside the bench.
// Depends on fdep_pkg and fat_directory_entry_parser.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_SIZE       = 64;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 40;

    // One result word as the block presents it
    typedef struct {
        fdep_pkg::t_status status;
        logic [15:0]       entry_index;
        logic [63:0]       short_name;
        logic [23:0]       short_ext;
        logic [7:0]        attributes;
        logic [31:0]       file_length;
        logic [31:0]       first_cluster;
        logic [7:0]        name_char;
    } t_dir_result;

    // DUT ports
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_action     = fdep_pkg::ACT_NONE;
    logic [7:0]  i_entry_byte = 8'h00;
    logic [5:0]  i_char_index = 6'h00;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [15:0] o_entry_index;
    logic [63:0] o_short_name;
    logic [23:0] o_short_ext;
    logic [7:0]  o_attributes;
    logic [31:0] o_file_length;
    logic [31:0] o_first_cluster;
    logic [7:0]  o_name_char;

    // Parser model state
    logic [7:0]  ent_buf [32];
    logic [4:0]  ent_pos    = '0;
    logic [15:0] ent_num    = '0;
    logic [7:0]  name_buf [NAME_SIZE];
    bit          dir_ended  = 1'b0;
    bit          name_stale = 1'b0;
    t_dir_result due_results [$];

    // Traffic shaping
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          interject_pct = 0;
    int          words_sent    = 0;
    int          fail_count    = 0;
    int          quiet_cycles  = 0;
    logic [7:0]  draft [32];

    fat_directory_entry_parser #(.LONG_NAME_SIZE(NAME_SIZE)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_entry_byte    (i_entry_byte),
        .i_char_index    (i_char_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index),
        .o_short_name    (o_short_name),
        .o_short_ext     (o_short_ext),
        .o_attributes    (o_attributes),
        .o_file_length   (o_file_length),
        .o_first_cluster (o_first_cluster),
        .o_name_char     (o_name_char)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Parser model
    //------------------------------------------------------------------
    function automatic void clear_names();
        foreach (name_buf[k]) name_buf[k] = 8'h00;
    endfunction

    function automatic t_dir_result blank_result(fdep_pkg::t_status st);
        t_dir_result r;
        r.status        = st;
        r.entry_index   = '0;
        r.short_name    = '0;
        r.short_ext     = '0;
        r.attributes    = '0;
        r.file_length   = '0;
        r.first_cluster = '0;
        r.name_char     = '0;
        return r;
    endfunction

    // Apply one accepted input word; queue the result word it causes, if any
    function automatic void parse_dir_word(logic [1:0] act, logic [7:0] b, logic [5:0] idx);
        t_dir_result r;
        logic [7:0]  attr;
        int          base;
        int          pos;
        case (act)
            fdep_pkg::ACT_START: begin
                clear_names();
                ent_pos    = '0;
                ent_num    = '0;
                dir_ended  = 1'b0;
                name_stale = 1'b0;
            end
            fdep_pkg::ACT_READ: begin
                r = blank_result(fdep_pkg::ST_CHAR);
                r.name_char = (idx < NAME_SIZE) ? name_buf[idx] : 8'h00;
                due_results.push_back(r);
            end
            fdep_pkg::ACT_BYTE: begin
                if (!dir_ended) begin
                    // store still holds the last file's name until the next entry starts
                    if (name_stale) begin
                        clear_names();
                        name_stale = 1'b0;
                    end
                    ent_buf[ent_pos] = b;
                    if (ent_pos != fdep_pkg::ENTRY_LAST) begin
                        ent_pos++;
                    end else begin
                        ent_pos = '0;
                        r = blank_result(fdep_pkg::ST_END);
                        r.entry_index = ent_num;
                        ent_num++;
                        attr = ent_buf[fdep_pkg::ATTR_BYTE];
                        if (ent_buf[0] == fdep_pkg::MARK_FREE) begin
                            dir_ended = 1'b1;
                        end else if (ent_buf[0] == fdep_pkg::MARK_DELETED) begin
                            r.status = fdep_pkg::ST_DELETED;
                        end else if (attr == fdep_pkg::ATTR_LFN) begin
                            r.status = fdep_pkg::ST_LFN;
                            // sequence zero gathers nothing; last store cell stays free
                            if ((ent_buf[0] & fdep_pkg::SEQ_MASK) != 0) begin
                                base = (int'(ent_buf[0] & fdep_pkg::SEQ_MASK) - 1) * 13;
                                for (int k = 0; k < 13; k++)
                                    if (base + k < NAME_SIZE - 1)
                                        name_buf[base + k] =
                                            ent_buf[fdep_pkg::LFN_OFFSETS[k]];
                            end
                        end else if ((attr & fdep_pkg::ATTR_SKIP) != 0) begin
                            r.status = fdep_pkg::ST_SKIP;
                            clear_names();
                        end else begin
                            r.status = fdep_pkg::ST_FILE;
                            for (int k = 0; k < 8; k++)
                                r.short_name = {r.short_name[55:0], ent_buf[k]};
                            r.short_ext     = {ent_buf[8], ent_buf[9], ent_buf[10]};
                            r.attributes    = attr;
                            r.file_length   = {ent_buf[31], ent_buf[30], ent_buf[29], ent_buf[28]};
                            r.first_cluster = {ent_buf[21], ent_buf[20], ent_buf[27], ent_buf[26]};
                            // no long name gathered: build NAME.EXT, except for dot names
                            if (name_buf[0] == 8'h00 && ent_buf[0] != fdep_pkg::CHAR_DOT) begin
                                pos = 0;
                                for (int k = 0; k < 11; k++) begin
                                    if (ent_buf[k] != fdep_pkg::CHAR_SPACE) begin
                                        name_buf[pos] = ent_buf[k];
                                        pos++;
                                    end
                                    if (k == 7) begin
                                        name_buf[pos] = fdep_pkg::CHAR_DOT;
                                        pos++;
                                    end
                                end
                                if (pos > 0 && name_buf[pos - 1] == fdep_pkg::CHAR_DOT)
                                    pos--;
                                name_buf[pos] = 8'h00;
                            end
                            name_stale = 1'b1;
                        end
                        due_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------
    // Send one word; returns at the falling edge after it was accepted
    task automatic send_word(logic [1:0] act, logic [7:0] b, logic [5:0] idx);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_entry_byte <= b;
        i_char_index <= idx;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        parse_dir_word(act, b, idx);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (due_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic read_chars(int first, int count);
        for (int k = 0; k < count; k++)
            send_word(fdep_pkg::ACT_READ, 8'($urandom), 6'(first + k));
    endtask

    // Send the drafted entry, with stray reads and undefined actions mixed in
    task automatic send_entry();
        foreach (draft[k]) begin
            if ($urandom_range(0, 99) < interject_pct)
                send_word(($urandom_range(0, 3) == 0) ? fdep_pkg::ACT_NONE : fdep_pkg::ACT_READ,
                          8'($urandom), 6'($urandom));
            send_word(fdep_pkg::ACT_BYTE, draft[k], 6'($urandom));
        end
    endtask

    //------------------------------------------------------------------
    // Entry builders
    //------------------------------------------------------------------
    function automatic void fill_random();
        foreach (draft[k]) draft[k] = 8'($urandom);
    endfunction

    function automatic void set_short(string s);
        for (int k = 0; k < 11; k++) draft[k] = s[k];
    endfunction

    // Short entry with an upper-case name padded by spaces
    function automatic void shape_file(logic [7:0] attr);
        int nlen;
        int elen;
        fill_random();
        nlen = $urandom_range(1, 8);
        elen = $urandom_range(0, 3);
        for (int k = 0; k < 8; k++)
            draft[k] = (k < nlen) ? 8'($urandom_range(8'h41, 8'h5A)) : fdep_pkg::CHAR_SPACE;
        for (int k = 0; k < 3; k++)
            draft[8 + k] = (k < elen) ? 8'($urandom_range(8'h41, 8'h5A)) :
                                        fdep_pkg::CHAR_SPACE;
        draft[11] = attr;
    endfunction

    // Long-name part; the last part of a name may end in a zero and 0xFF padding
    function automatic void shape_lfn(logic [7:0] seq_byte, bit last_part);
        int stop;
        fill_random();
        stop = last_part ? $urandom_range(0, 13) : 13;
        for (int k = 0; k < 13; k++)
            draft[fdep_pkg::LFN_OFFSETS[k]] = (k < stop) ? 8'($urandom_range(8'h61, 8'h7A)) :
                                              (k == stop) ? 8'h00 : 8'hFF;
        draft[0]  = seq_byte;
        draft[11] = fdep_pkg::ATTR_LFN;
    endfunction

    // Well-formed run of long-name parts, highest first, then the short entry
    task automatic send_long_named_file(int parts);
        for (int p = parts; p >= 1; p--) begin
            shape_lfn(8'(p) | ((p == parts) ? 8'h40 : 8'h00), p == parts);
            send_entry();
        end
        shape_file(8'($urandom) & ~fdep_pkg::ATTR_SKIP);
        send_entry();
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    task automatic test_reset_state();
        // store is empty out of reset; undefined action is dropped
        read_chars(0, 2);
        send_word(fdep_pkg::ACT_READ, 8'hFF, 6'h3F);
        send_word(fdep_pkg::ACT_NONE, 8'hFF, 6'h3F);
        send_word(fdep_pkg::ACT_NONE, 8'h00, 6'h00);
    endtask

    task automatic test_entry_kinds();
        send_word(fdep_pkg::ACT_START, 8'h00, 6'h00);
        fill_random();
        draft[0] = fdep_pkg::MARK_DELETED;
        send_entry();
        shape_file(fdep_pkg::ATTR_SKIP);
        send_entry();
        shape_file(8'h08);
        send_entry();
        shape_file(8'h20);
        send_entry();
        read_chars(0, 12);
    endtask

    task automatic test_long_names();
        send_word(fdep_pkg::ACT_START, 8'hFF, 6'h3F);
        shape_lfn(8'h42, 1'b1);
        send_entry();
        shape_lfn(8'h01, 1'b0);
        send_entry();
        shape_file(8'h20);
        send_entry();
        read_chars(0, 28);
        // sequence zero gathers nothing
        shape_lfn(8'h40, 1'b1);
        send_entry();
        read_chars(0, 2);
        // sequence five runs off the end of the store
        shape_lfn(8'h45, 1'b0);
        send_entry();
        read_chars(50, 14);
        // highest sequence lands wholly outside
        shape_lfn(8'h7F, 1'b0);
        send_entry();
        // hidden entry drops the gathered name, next file builds its own
        shape_file(8'h02);
        send_entry();
        shape_file(8'h00);
        send_entry();
        read_chars(0, 12);
    endtask

    task automatic test_short_names();
        send_word(fdep_pkg::ACT_START, 8'h00, 6'h00);
        shape_file(8'h00);
        set_short("AB      TXT");
        send_entry();
        read_chars(0, 7);
        // no extension: trailing dot dropped
        shape_file(8'h01);
        set_short("README     ");
        send_entry();
        read_chars(5, 3);
        // dot name copies nothing
        shape_file(8'h10);
        set_short("..         ");
        send_entry();
        read_chars(0, 2);
        // all ones wherever a file allows it
        foreach (draft[k]) draft[k] = 8'hFF;
        draft[11] = ~fdep_pkg::ATTR_SKIP;
        send_entry();
        read_chars(8, 6);
        // all zeros behind a nonzero first byte
        foreach (draft[k]) draft[k] = 8'h00;
        draft[0] = 8'h01;
        send_entry();
        read_chars(0, 2);
    endtask

    task automatic test_end_of_directory();
        send_word(fdep_pkg::ACT_START, 8'h00, 6'h00);
        fill_random();
        draft[0] = fdep_pkg::MARK_DELETED;
        send_entry();
        fill_random();
        draft[0] = fdep_pkg::MARK_FREE;
        send_entry();
        // bytes are ignored until the next start, reads still answer
        repeat (40) send_word(fdep_pkg::ACT_BYTE, 8'($urandom), 6'($urandom));
        read_chars(0, 2);
        drain_results();
        send_word(fdep_pkg::ACT_START, 8'h00, 6'h00);
        // partial entry thrown away by a start
        repeat (10) send_word(fdep_pkg::ACT_BYTE, fdep_pkg::MARK_DELETED, 6'h00);
        send_word(fdep_pkg::ACT_START, 8'h00, 6'h00);
        fill_random();
        draft[0] = fdep_pkg::MARK_DELETED;
        send_entry();
    endtask

    task automatic random_entry();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_long_named_file($urandom_range(1, 5));
            read_chars(0, $urandom_range(1, 6));
        end else if (pick < 55) begin
            shape_file(8'($urandom) & ~fdep_pkg::ATTR_SKIP);
            if ($urandom_range(0, 9) == 0)
                draft[0] = fdep_pkg::CHAR_DOT;
            send_entry();
            read_chars(0, $urandom_range(1, 13));
        end else if (pick < 65) begin
            fill_random();
            draft[0] = fdep_pkg::MARK_DELETED;
            send_entry();
        end else if (pick < 75) begin
            shape_file(8'($urandom) | (8'h02 << $urandom_range(0, 2)));
            send_entry();
        end else if (pick < 85) begin
            // stray long-name part: any sequence byte, zero and out of range too
            shape_lfn(8'($urandom), 1'b1);
            send_entry();
        end else if (pick < 92) begin
            fill_random();
            send_entry();
        end else begin
            // partial entry cut off by a new start
            repeat ($urandom_range(1, 31))
                send_word(fdep_pkg::ACT_BYTE, 8'($urandom), 6'($urandom));
            send_word(fdep_pkg::ACT_START, 8'($urandom), 6'($urandom));
        end
    endtask

    task automatic random_listing();
        send_word(fdep_pkg::ACT_START, 8'($urandom), 6'($urandom));
        repeat ($urandom_range(1, 4)) random_entry();
        if ($urandom_range(0, 1) == 0) begin
            fill_random();
            draft[0] = fdep_pkg::MARK_FREE;
            send_entry();
            repeat ($urandom_range(0, 8))
                send_word(fdep_pkg::ACT_BYTE, 8'($urandom), 6'($urandom));
            read_chars($urandom_range(0, 63), 2);
        end
    endtask

    task automatic run_phase(int gap_pct, int hold_pct);
        int goal;
        idle_pct  = gap_pct;
        stall_pct = hold_pct;
        goal = words_sent + ITEMS_PER_PHASE;
        while (words_sent < goal)
            random_listing();
        drain_results();
    endtask

    task automatic test_random_traffic();
        interject_pct = 4;
        run_phase(0, 0);
        run_phase(54, 0);
        run_phase(0, 54);
        run_phase(26, 26);
    endtask

    //------------------------------------------------------------------
    // Output side
    //------------------------------------------------------------------
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_dir_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: status %0d index %0d",
                             o_status, o_entry_index);
            end else begin
                want = due_results.pop_front();
                if (o_status !== want.status || o_entry_index !== want.entry_index ||
                    o_short_name !== want.short_name || o_short_ext !== want.short_ext ||
                    o_attributes !== want.attributes || o_file_length !== want.file_length ||
                    o_first_cluster !== want.first_cluster ||
                    o_name_char !== want.name_char) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch, expected: st %0d idx %h name %h ext %h attr %h",
                                 want.status, want.entry_index, want.short_name,
                                 want.short_ext, want.attributes);
                        $display("    len %h clus %h char %h", want.file_length,
                                 want.first_cluster, want.name_char);
                        $display("  actual:           st %0d idx %h name %h ext %h attr %h",
                                 o_status, o_entry_index, o_short_name, o_short_ext,
                                 o_attributes);
                        $display("    len %h clus %h char %h", o_file_length,
                                 o_first_cluster, o_name_char);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        clear_names();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_entry_kinds();
        test_long_names();
        test_short_names();
        test_end_of_directory();
        drain_results();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
